// ===== hdl/hash_table_internal_chaining_unit_macros.svh =====
// Assertion helpers for the controller RTL, which checks its own logic.
`ifndef HASH_TABLE_INTERNAL_CHAINING_UNIT_MACROS_SVH
`define HASH_TABLE_INTERNAL_CHAINING_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTC_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash table unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash table unit: next-cycle check failed");

`endif

// ===== hdl/htc_pkg.sv =====
`timescale 1ns / 1ps

package htc_pkg;

   localparam int MODE_W             = 2;
   localparam int KEY_W              = 32;
   localparam int VAL_W              = 64;
   localparam int STATUS_W           = 2;
   localparam int SLOT_W             = 10;
   localparam int TABLE_SIZE_DEFAULT = 1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_PRESENT   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // One command per cycle to the slot memories: a read of every field at
   // one address, and a write of the selected fields at another.
   typedef struct packed {
      logic rd_en;
      logic wr_occ;
      logic wr_key;
      logic wr_val;
      logic wr_prev;
      logic wr_next;
   } mem_cmd_type;

endpackage

// ===== hdl/htc_if.sv =====
`timescale 1ns / 1ps

interface htc_req_if import htc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [KEY_W-1:0]  key;
   logic [VAL_W-1:0]  value;

   modport source (output valid, mode, key, value, input ready);
   modport sink   (input valid, mode, key, value, output ready);
endinterface

interface htc_rsp_if import htc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [VAL_W-1:0]    found_value;

   modport source (output valid, status, slot, found_value, input ready);
   modport sink   (input valid, status, slot, found_value, output ready);
endinterface

// ===== hdl/hash_table_internal_chaining_unit.sv =====
`timescale 1ns / 1ps
// Insertions that relocate a slot take the longest, and each chain member walked past the
// home slot adds to a request's time. Requests are taken one at a time; the next is taken
// the cycle after the result enters the output register.
// Reset: synchronous, active high; a clearing pass over every slot then rebuilds the free
// list and marks every slot free, and no request is taken until it ends.

// Hash table with the chains kept inside the table. The controller walks the
// chains and sequences the read and write steps of each operation; the slot
// store keeps one array per field; a reciprocal remainder unit gives home slots.
module hash_table_internal_chaining_unit import htc_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   htc_req_if.sink   req_chan,
   htc_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(TABLE_SIZE);

   // Command path from the controller to the remainder unit.
   logic             mod_start;
   logic [KEY_W-1:0] mod_dividend;
   logic             mod_done;
   logic [IDX_W-1:0] mod_rem;

   // Command path to the slot store and the registered read data back.
   mem_cmd_type      cmd;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic             wd_occ;
   logic [KEY_W-1:0] wd_key;
   logic [VAL_W-1:0] wd_val;
   logic [IDX_W:0]   wd_prev;
   logic [IDX_W:0]   wd_next;
   logic             rd_occ;
   logic [KEY_W-1:0] rd_key;
   logic [VAL_W-1:0] rd_val;
   logic [IDX_W:0]   rd_prev;
   logic [IDX_W:0]   rd_next;

   // The controller also owns the request and result handshakes, so a
   // finished result waits in its output register while the next request
   // is taken.
   htc_ctrl #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .mod_start    (mod_start),
      .mod_dividend (mod_dividend),
      .mod_done     (mod_done),
      .mod_rem      (mod_rem),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .wd_occ       (wd_occ),
      .wd_key       (wd_key),
      .wd_val       (wd_val),
      .wd_prev      (wd_prev),
      .wd_next      (wd_next),
      .rd_occ       (rd_occ),
      .rd_key       (rd_key),
      .rd_val       (rd_val),
      .rd_prev      (rd_prev),
      .rd_next      (rd_next)
   );

   // Home slot of a key by reciprocal multiplication. It serves both the
   // incoming key and the key of a home slot's occupant.
   htc_mod #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Slot store. Links carry a null flag above the slot index.
   htc_mem #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_mem (
      .clock   (clock),
      .cmd     (cmd),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wd_occ  (wd_occ),
      .wd_key  (wd_key),
      .wd_val  (wd_val),
      .wd_prev (wd_prev),
      .wd_next (wd_next),
      .rd_occ  (rd_occ),
      .rd_key  (rd_key),
      .rd_val  (rd_val),
      .rd_prev (rd_prev),
      .rd_next (rd_next)
   );

endmodule

// ===== hdl/htc_mod.sv =====
`timescale 1ns / 1ps

// Remainder by the table size through a reciprocal multiply. The quotient is
// the high half of the product with one fix-up step, and the remainder is
// what is left after one multiply and subtract. The dividend, the high half
// of the product, the quotient and the remainder are registered in turn.
module htc_mod import htc_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_W-1:0]              dividend,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] remainder
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int SH    = IDX_W - 1;
   // Scaled reciprocal for the chosen shift; it is one for a power-of-two size.
   localparam longint unsigned RECIP_WIDE =
      (((64'd1 << IDX_W) - 64'(TABLE_SIZE)) << KEY_W) / 64'(TABLE_SIZE) + 64'd1;
   localparam logic [KEY_W-1:0] RECIP = KEY_W'(RECIP_WIDE);
   localparam logic [KEY_W-1:0] DIV_V = KEY_W'(TABLE_SIZE);

   logic [3:0]         stage_ff, stage_in;
   logic [KEY_W-1:0]   num_ff, num_in;
   logic [KEY_W-1:0]   t1_ff, t1_in;
   logic [KEY_W-1:0]   q_ff, q_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic [2*KEY_W-1:0] prod;
   logic [KEY_W-1:0]   qd;

   assign prod = (2*KEY_W)'(num_ff) * (2*KEY_W)'(RECIP);
   // The product never exceeds the dividend, so it fits the key width.
   assign qd   = q_ff * DIV_V;

   always_comb begin
      stage_in = {stage_ff[2:0], start};
      num_in   = start ? dividend : num_ff;
      t1_in    = prod[2*KEY_W-1:KEY_W];
      q_in     = (t1_ff + ((num_ff - t1_ff) >> 1)) >> SH;
      rem_in   = IDX_W'(num_ff - qd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      num_ff <= num_in;
      t1_ff  <= t1_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done      = stage_ff[3];
   assign remainder = rem_ff;

endmodule

// ===== hdl/htc_mem.sv =====
`timescale 1ns / 1ps

// Slot store: one array per field, a shared read address with registered
// read data, and a write address with a per-field write enable.
module htc_mem import htc_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  mem_cmd_type                   cmd,
   input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   input  logic                          wd_occ,
   input  logic [KEY_W-1:0]              wd_key,
   input  logic [VAL_W-1:0]              wd_val,
   input  logic [$clog2(TABLE_SIZE):0]   wd_prev,
   input  logic [$clog2(TABLE_SIZE):0]   wd_next,
   output logic                          rd_occ,
   output logic [KEY_W-1:0]              rd_key,
   output logic [VAL_W-1:0]              rd_val,
   output logic [$clog2(TABLE_SIZE):0]   rd_prev,
   output logic [$clog2(TABLE_SIZE):0]   rd_next
);

   localparam int LW = $clog2(TABLE_SIZE) + 1;

   logic             occ_mem  [TABLE_SIZE];
   logic [KEY_W-1:0] key_mem  [TABLE_SIZE];
   logic [VAL_W-1:0] val_mem  [TABLE_SIZE];
   logic [LW-1:0]    prev_mem [TABLE_SIZE];
   logic [LW-1:0]    next_mem [TABLE_SIZE];

   always_ff @(posedge clock) begin
      if (cmd.wr_occ) begin
         occ_mem[wr_addr] <= wd_occ;
      end
      if (cmd.wr_key) begin
         key_mem[wr_addr] <= wd_key;
      end
      if (cmd.wr_val) begin
         val_mem[wr_addr] <= wd_val;
      end
      if (cmd.wr_prev) begin
         prev_mem[wr_addr] <= wd_prev;
      end
      if (cmd.wr_next) begin
         next_mem[wr_addr] <= wd_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_occ  <= occ_mem[rd_addr];
         rd_key  <= key_mem[rd_addr];
         rd_val  <= val_mem[rd_addr];
         rd_prev <= prev_mem[rd_addr];
         rd_next <= next_mem[rd_addr];
      end
   end

endmodule

// ===== hdl/htc_ctrl.sv =====
`timescale 1ns / 1ps
`include "hash_table_internal_chaining_unit_macros.svh"

// Sequencer for the reset clearing pass and for insert, lookup and remove over the slot store.
module htc_ctrl import htc_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   htc_req_if.sink                       req_chan,
   htc_rsp_if.source                     rsp_chan,
   output logic                          mod_start,
   output logic [KEY_W-1:0]              mod_dividend,
   input  logic                          mod_done,
   input  logic [$clog2(TABLE_SIZE)-1:0] mod_rem,
   output mem_cmd_type                   cmd,
   output logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   output logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   output logic                          wd_occ,
   output logic [KEY_W-1:0]              wd_key,
   output logic [VAL_W-1:0]              wd_val,
   output logic [$clog2(TABLE_SIZE):0]   wd_prev,
   output logic [$clog2(TABLE_SIZE):0]   wd_next,
   input  logic                          rd_occ,
   input  logic [KEY_W-1:0]              rd_key,
   input  logic [VAL_W-1:0]              rd_val,
   input  logic [$clog2(TABLE_SIZE):0]   rd_prev,
   input  logic [$clog2(TABLE_SIZE):0]   rd_next
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int LW    = IDX_W + 1;
   localparam logic [LW-1:0]    NIL      = {1'b1, {IDX_W{1'b0}}};
   localparam logic [IDX_W:0]   TS_V     = (IDX_W+1)'(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_HASH, S_HOME, S_HASH2, S_FIND,
      S_IF_W1, S_IF_W2, S_PUT_HEAD,
      S_FR_W1, S_FR_W2, S_OW_W1, S_RD_R, S_UNL, S_UNL2, S_MOVE,
      S_RM0, S_RM1, S_RM2, S_RM3, S_RM4, S_RM_OH,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]  h_ff, h_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  r_ff, r_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [LW-1:0]     sp_ff, sp_in;
   logic [LW-1:0]     sn_ff, sn_in;
   logic [KEY_W-1:0]  skey_ff, skey_in;
   logic [VAL_W-1:0]  sval_ff, sval_in;
   logic              socc_ff, socc_in;
   logic [LW-1:0]     tp_ff, tp_in;
   logic [LW-1:0]     tn_ff, tn_in;
   logic [LW-1:0]     oh_ff, oh_in;
   logic [LW-1:0]     fh_ff, fh_in;
   logic [LW-1:0]     mprev_ff, mprev_in;
   logic [LW-1:0]     pnext_ff, pnext_in;
   status_type        res_status_ff, res_status_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [VAL_W-1:0]  res_fv_ff, res_fv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [VAL_W-1:0]  out_fv_ff, out_fv_in;

   logic              req_fire;
   logic              load_out;
   logic [IDX_W:0]    clr_p1;

   assign req_fire = req_chan.valid && (state_ff == S_IDLE);
   assign clr_p1   = {1'b0, clr_ff} + 1'b1;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      h_in          = h_ff;
      cur_in        = cur_ff;
      r_in          = r_ff;
      clr_in        = clr_ff;
      sp_in         = sp_ff;
      sn_in         = sn_ff;
      skey_in       = skey_ff;
      sval_in       = sval_ff;
      socc_in       = socc_ff;
      tp_in         = tp_ff;
      tn_in         = tn_ff;
      oh_in         = oh_ff;
      fh_in         = fh_ff;
      mprev_in      = mprev_ff;
      pnext_in      = pnext_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_fv_in     = res_fv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_fv_in     = out_fv_ff;
      load_out      = 1'b0;

      cmd          = '0;
      rd_addr      = h_ff;
      wr_addr      = h_ff;
      wd_occ       = 1'b0;
      wd_key       = key_ff;
      wd_val       = val_ff;
      wd_prev      = NIL;
      wd_next      = NIL;
      mod_start    = 1'b0;
      mod_dividend = (state_ff == S_IDLE) ? req_chan.key : rd_key;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_occ  = 1'b1;
            cmd.wr_prev = 1'b1;
            cmd.wr_next = 1'b1;
            wr_addr     = clr_ff;
            wd_prev     = (clr_p1 < TS_V) ? {1'b0, clr_p1[IDX_W-1:0]} : NIL;
            wd_next     = (clr_ff == '0) ? NIL : {1'b0, clr_ff - 1'b1};
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               mode_in     = mode_type'(req_chan.mode);
               key_in      = req_chan.key;
               val_in      = req_chan.value;
               res_slot_in = '0;
               res_fv_in   = '0;
               if (mode_type'(req_chan.mode) == MODE_NONE) begin
                  res_status_in = STATUS_DONE;
                  state_in      = S_FINISH;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (mod_done) begin
               h_in       = mod_rem;
               cmd.rd_en  = 1'b1;
               rd_addr    = mod_rem;
               state_in   = S_HOME;
            end
         end
         S_HOME: begin
            sp_in   = rd_prev;
            sn_in   = rd_next;
            skey_in = rd_key;
            sval_in = rd_val;
            socc_in = rd_occ;
            cur_in  = h_ff;
            if (mode_ff == MODE_INSERT) begin
               if (!rd_occ) begin
                  tp_in    = rd_prev;
                  tn_in    = rd_next;
                  state_in = S_IF_W1;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_HASH2;
               end
            end else if (!rd_occ) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = S_FINISH;
            end else begin
               state_in = S_FIND;
            end
         end
         S_HASH2: begin
            // The read data still holds the home slot while the occupant hashes.
            if (mod_done) begin
               state_in = (mod_rem != h_ff) ? S_FR_W1 : S_FIND;
            end
         end
         S_FIND: begin
            if (rd_key == key_ff) begin
               res_slot_in = SLOT_W'(cur_ff);
               priority case (mode_ff)
                  MODE_INSERT: begin
                     res_status_in = STATUS_PRESENT;
                     state_in      = S_FINISH;
                  end
                  MODE_LOOKUP: begin
                     res_status_in = STATUS_DONE;
                     res_fv_in     = rd_val;
                     state_in      = S_FINISH;
                  end
                  default: begin
                     sp_in    = rd_prev;
                     sn_in    = rd_next;
                     state_in = S_RM0;
                  end
               endcase
            end else if (rd_next[LW-1]) begin
               if (mode_ff == MODE_INSERT) begin
                  state_in = S_OW_W1;
               end else begin
                  res_status_in = STATUS_NOT_FOUND;
                  state_in      = S_FINISH;
               end
            end else begin
               cur_in    = rd_next[IDX_W-1:0];
               cmd.rd_en = 1'b1;
               rd_addr   = rd_next[IDX_W-1:0];
            end
         end
         S_IF_W1: begin
            if (tp_ff[LW-1]) begin
               fh_in = tn_ff;
            end else begin
               cmd.wr_next = 1'b1;
               wr_addr     = tp_ff[IDX_W-1:0];
               wd_next     = tn_ff;
            end
            state_in = S_IF_W2;
         end
         S_IF_W2: begin
            if (!tn_ff[LW-1]) begin
               cmd.wr_prev = 1'b1;
               wr_addr     = tn_ff[IDX_W-1:0];
               wd_prev     = tp_ff;
            end
            pnext_in = NIL;
            state_in = S_PUT_HEAD;
         end
         S_PUT_HEAD: begin
            cmd.wr_occ    = 1'b1;
            cmd.wr_key    = 1'b1;
            cmd.wr_val    = 1'b1;
            cmd.wr_prev   = 1'b1;
            cmd.wr_next   = 1'b1;
            wd_occ        = 1'b1;
            wd_next       = pnext_ff;
            res_status_in = STATUS_DONE;
            res_slot_in   = SLOT_W'(h_ff);
            state_in      = S_FINISH;
         end
         S_FR_W1: begin
            if (fh_ff[LW-1]) begin
               res_status_in = STATUS_FULL;
               res_slot_in   = SLOT_W'(h_ff);
               state_in      = S_FINISH;
            end else begin
               r_in     = fh_ff[IDX_W-1:0];
               mprev_in = sp_ff;
               pnext_in = NIL;
               if (!sp_ff[LW-1]) begin
                  cmd.wr_next = 1'b1;
                  wr_addr     = sp_ff[IDX_W-1:0];
                  wd_next     = fh_ff;
               end
               state_in = S_FR_W2;
            end
         end
         S_FR_W2: begin
            if (!sn_ff[LW-1]) begin
               cmd.wr_prev = 1'b1;
               wr_addr     = sn_ff[IDX_W-1:0];
               wd_prev     = {1'b0, r_ff};
            end
            state_in = S_RD_R;
         end
         S_OW_W1: begin
            if (fh_ff[LW-1]) begin
               res_status_in = STATUS_FULL;
               res_slot_in   = SLOT_W'(h_ff);
               state_in      = S_FINISH;
            end else begin
               r_in     = fh_ff[IDX_W-1:0];
               mprev_in = {1'b0, h_ff};
               pnext_in = fh_ff;
               if (!sn_ff[LW-1]) begin
                  cmd.wr_prev = 1'b1;
                  wr_addr     = sn_ff[IDX_W-1:0];
                  wd_prev     = fh_ff;
               end
               state_in = S_RD_R;
            end
         end
         S_RD_R: begin
            cmd.rd_en = 1'b1;
            rd_addr   = r_ff;
            state_in  = S_UNL;
         end
         S_UNL: begin
            tp_in = rd_prev;
            tn_in = rd_next;
            if (rd_prev[LW-1]) begin
               fh_in = rd_next;
            end else begin
               cmd.wr_next = 1'b1;
               wr_addr     = rd_prev[IDX_W-1:0];
               wd_next     = rd_next;
            end
            state_in = S_UNL2;
         end
         S_UNL2: begin
            if (!tn_ff[LW-1]) begin
               cmd.wr_prev = 1'b1;
               wr_addr     = tn_ff[IDX_W-1:0];
               wd_prev     = tp_ff;
            end
            state_in = S_MOVE;
         end
         S_MOVE: begin
            cmd.wr_occ  = 1'b1;
            cmd.wr_key  = 1'b1;
            cmd.wr_val  = 1'b1;
            cmd.wr_prev = 1'b1;
            cmd.wr_next = 1'b1;
            wr_addr     = r_ff;
            wd_occ      = socc_ff;
            wd_key      = skey_ff;
            wd_val      = sval_ff;
            wd_prev     = mprev_ff;
            wd_next     = sn_ff;
            state_in    = S_PUT_HEAD;
         end
         S_RM0: begin
            oh_in = fh_ff;
            if (sn_ff[LW-1]) begin
               fh_in = {1'b0, cur_ff};
               if (!sp_ff[LW-1]) begin
                  cmd.wr_next = 1'b1;
                  wr_addr     = sp_ff[IDX_W-1:0];
                  wd_next     = NIL;
               end
               state_in = S_RM1;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = sn_ff[IDX_W-1:0];
               state_in  = S_RM2;
            end
         end
         S_RM1: begin
            cmd.wr_occ  = 1'b1;
            cmd.wr_prev = 1'b1;
            cmd.wr_next = 1'b1;
            wr_addr     = cur_ff;
            wd_next     = oh_ff;
            state_in    = S_RM_OH;
         end
         S_RM2: begin
            cmd.wr_occ  = 1'b1;
            cmd.wr_key  = 1'b1;
            cmd.wr_val  = 1'b1;
            cmd.wr_prev = 1'b1;
            cmd.wr_next = 1'b1;
            wr_addr     = cur_ff;
            wd_occ      = rd_occ;
            wd_key      = rd_key;
            wd_val      = rd_val;
            wd_prev     = sp_ff;
            wd_next     = rd_next;
            tn_in       = rd_next;
            fh_in       = sn_ff;
            state_in    = S_RM3;
         end
         S_RM3: begin
            cmd.wr_occ  = 1'b1;
            cmd.wr_prev = 1'b1;
            cmd.wr_next = 1'b1;
            wr_addr     = sn_ff[IDX_W-1:0];
            wd_next     = oh_ff;
            state_in    = S_RM4;
         end
         S_RM4: begin
            if (!tn_ff[LW-1]) begin
               cmd.wr_prev = 1'b1;
               wr_addr     = tn_ff[IDX_W-1:0];
               wd_prev     = {1'b0, cur_ff};
            end
            state_in = S_RM_OH;
         end
         S_RM_OH: begin
            if (!oh_ff[LW-1]) begin
               cmd.wr_prev = 1'b1;
               wr_addr     = oh_ff[IDX_W-1:0];
               wd_prev     = fh_ff;
            end
            res_status_in = STATUS_DONE;
            res_slot_in   = SLOT_W'(cur_ff);
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out      = 1'b1;
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_slot_in   = res_slot_ff;
               out_fv_in     = res_fv_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         fh_ff        <= {1'b0, LAST_IDX};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fh_ff        <= fh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      h_ff          <= h_in;
      cur_ff        <= cur_in;
      r_ff          <= r_in;
      sp_ff         <= sp_in;
      sn_ff         <= sn_in;
      skey_ff       <= skey_in;
      sval_ff       <= sval_in;
      socc_ff       <= socc_in;
      tp_ff         <= tp_in;
      tn_ff         <= tn_in;
      oh_ff         <= oh_in;
      mprev_ff      <= mprev_in;
      pnext_ff      <= pnext_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_fv_ff     <= res_fv_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_fv_ff     <= out_fv_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.slot        = out_slot_ff;
   assign rsp_chan.found_value = out_fv_ff;

   `HTC_ASSERT(a_out_reg_free, clock, reset, load_out, !rsp_valid_ff || rsp_chan.ready)
   `HTC_ASSERT(a_remove_frees_slot, clock, reset, state_ff == S_RM_OH, !fh_ff[LW-1])
   `HTC_ASSERT(a_hash_in_range, clock, reset, mod_done, ({1'b0, mod_rem} < TS_V))
   `HTC_ASSERT_NEXT(a_accept_hashes, clock, reset,
                    req_fire && (mode_type'(req_chan.mode) != MODE_NONE), state_ff == S_HASH)

endmodule

// ===== verif/htc_tb_if.sv =====
`timescale 1ns / 1ps

// Channel interfaces come from the RTL (htc_req_if, htc_rsp_if); this file
// only carries the answer record type used by the bench.
package htc_tb_pkg;
   import htc_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [VAL_W-1:0]    found_value;
   } answer_type;
endpackage

// ===== verif/hash_table_internal_chaining_unit_test.sv =====
`timescale 1ns / 1ps

// Checks the hash table unit against a behavioural shadow of the table.
// A scoreboard class keeps its own copy of the slot store and free list,
// works out the answer of every accepted request and compares each result
// in order.
class table_scoreboard;
   localparam int N   = 1024;
   localparam int NIL = -1;

   bit                      occ[N];
   logic [31:0]             keys[N];
   logic [63:0]             vals[N];
   int                      prv[N];
   int                      nxt[N];
   int                      free_head;
   htc_tb_pkg::answer_type  pending[$];
   int                      errors;
   int                      checked;
   int                      hits;

   function void clear();
      for (int i = 0; i < N; i++) begin
         occ[i] = 0;
         keys[i] = 0;
         vals[i] = 0;
         prv[i] = (i + 1 < N) ? i + 1 : NIL;
         nxt[i] = (i > 0) ? i - 1 : NIL;
      end
      free_head = N - 1;
      pending.delete();
   endfunction

   function void unlink_free(int s);
      int p, n;
      p = prv[s];
      n = nxt[s];
      if (p == NIL) free_head = n;
      else nxt[p] = n;
      if (n != NIL) prv[n] = p;
   endfunction

   function int find(logic [31:0] k);
      int idx;
      idx = k % N;
      if (!occ[idx]) return NIL;
      for (int s = 0; s < N; s++) begin
         if (keys[idx] == k) return idx;
         if (nxt[idx] == NIL) return NIL;
         idx = nxt[idx];
      end
      return NIL;
   endfunction

   function void move(int from, int to);
      occ[to] = occ[from];
      keys[to] = keys[from];
      vals[to] = vals[from];
      prv[to] = prv[from];
      nxt[to] = nxt[from];
   endfunction

   function void put_head(int h, logic [31:0] k, logic [63:0] v, int n);
      occ[h] = 1;
      keys[h] = k;
      vals[h] = v;
      prv[h] = NIL;
      nxt[h] = n;
   endfunction

   function htc_pkg::status_type insert(logic [31:0] k, logic [63:0] v, output int slot);
      int h, r, f;
      h = k % N;
      slot = h;
      if (!occ[h]) begin
         unlink_free(h);
         put_head(h, k, v, NIL);
         return htc_pkg::STATUS_DONE;
      end
      if (keys[h] % N != h) begin
         r = free_head;
         if (r == NIL) return htc_pkg::STATUS_FULL;
         if (prv[h] != NIL) nxt[prv[h]] = r;
         if (nxt[h] != NIL) prv[nxt[h]] = r;
         unlink_free(r);
         move(h, r);
         put_head(h, k, v, NIL);
         return htc_pkg::STATUS_DONE;
      end
      f = find(k);
      if (f != NIL) begin
         slot = f;
         return htc_pkg::STATUS_PRESENT;
      end
      r = free_head;
      if (r == NIL) return htc_pkg::STATUS_FULL;
      if (nxt[h] != NIL) prv[nxt[h]] = r;
      unlink_free(r);
      move(h, r);
      prv[r] = h;
      put_head(h, k, v, r);
      return htc_pkg::STATUS_DONE;
   endfunction

   function htc_pkg::status_type remove(logic [31:0] k, output int slot);
      int idx, old_head, p, n;
      idx = find(k);
      old_head = free_head;
      slot = 0;
      if (idx == NIL) return htc_pkg::STATUS_NOT_FOUND;
      slot = idx;
      p = prv[idx];
      n = nxt[idx];
      if (n == NIL) begin
         free_head = idx;
         if (p != NIL) nxt[p] = NIL;
         occ[idx] = 0;
         prv[idx] = NIL;
         nxt[idx] = old_head;
      end else begin
         move(n, idx);
         prv[idx] = p;
         free_head = n;
         occ[n] = 0;
         prv[n] = NIL;
         nxt[n] = old_head;
         if (nxt[idx] != NIL) prv[nxt[idx]] = idx;
      end
      if (old_head != NIL) prv[old_head] = free_head;
      return htc_pkg::STATUS_DONE;
   endfunction

   // Notes an accepted request and queues the answer it must produce.
   function void note_request(htc_pkg::mode_type m, logic [31:0] k, logic [63:0] v);
      htc_tb_pkg::answer_type a;
      int slot, f;
      a.status = htc_pkg::STATUS_DONE;
      a.found_value = '0;
      slot = 0;
      case (m)
         htc_pkg::MODE_INSERT: a.status = insert(k, v, slot);
         htc_pkg::MODE_LOOKUP: begin
            f = find(k);
            if (f == NIL) a.status = htc_pkg::STATUS_NOT_FOUND;
            else begin
               slot = f;
               a.found_value = vals[f];
               hits++;
            end
         end
         htc_pkg::MODE_REMOVE: a.status = remove(k, slot);
         default: ;
      endcase
      a.slot = slot[9:0];
      pending.push_back(a);
   endfunction

   function void check_result(logic [1:0] st, logic [9:0] sl, logic [63:0] fv);
      htc_tb_pkg::answer_type e;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("Unexpected result: status %0d slot %0d", st, sl);
         return;
      end
      e = pending.pop_front();
      if (e.status !== st || e.slot !== sl || e.found_value !== fv) begin
         errors++;
         if (errors <= 10)
            $display("Result %0d: expected %0d/%0d/%h, got %0d/%0d/%h", checked,
                     e.status, e.slot, e.found_value, st, sl, fv);
      end
   endfunction
endclass

module hash_table_internal_chaining_unit_test;
   import htc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   int   idle_cycles;
   int   sent;

   htc_req_if req_chan ();
   htc_rsp_if rsp_chan ();

   table_scoreboard table_model = new();

   logic [31:0] used_keys[$];

   hash_table_internal_chaining_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, and stretches with none.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Presents one request and holds it until the unit accepts it. Valid
   // stays high into the next request when there is no gap.
   task automatic send_request(mode_type m, logic [31:0] k, logic [63:0] v);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode  <= m;
      req_chan.key   <= k;
      req_chan.value <= v;
      do @(posedge clock); while (!req_chan.ready);
      table_model.note_request(m, k, v);
      sent++;
   endtask

   // Mostly picks a key that shares a home slot with an earlier one, so chains grow.
   function automatic logic [31:0] chained_key();
      logic [31:0] base;
      if (used_keys.size() == 0 || $urandom_range(0, 2) == 0) begin
         base = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 63);
      end else begin
         base = used_keys[$urandom_range(0, used_keys.size() - 1)];
         if ($urandom_range(0, 1)) base = base + 1024 * $urandom_range(1, 8);
      end
      return base;
   endfunction

   // The response side stalls at random: ready is low with a probability of 3/10.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            table_model.check_result(rsp_chan.status, rsp_chan.slot, rsp_chan.found_value);
         rsp_chan.ready <= ($urandom_range(0, 9) < 7);
      end
   end

   // Watchdog: counts cycles in which no request or result is accepted.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d requests", sent);
         $display("hash_table_internal_chaining_unit: mismatch");
         $finish;
      end
   end

   initial begin
      logic [31:0] k;
      mode_type    m;
      int          fill;
      table_model.clear();
      sent           = 0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode  = MODE_NONE;
      req_chan.key   = '0;
      req_chan.value = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: field extremes, every operation, a duplicate, a
      // foreign chain displaced from its home slot and chain members behind the head removed.
      send_request(MODE_LOOKUP, 32'hFFFF_FFFF, '1);
      send_request(MODE_REMOVE, 32'd5, '0);
      send_request(MODE_NONE, 32'hFFFF_FFFF, '1);
      send_request(MODE_INSERT, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(MODE_INSERT, 32'hFFFF_FFFF, 64'h0);
      send_request(MODE_INSERT, 32'd1023, 64'h1234);
      send_request(MODE_INSERT, 32'd2047, 64'h5555_AAAA_5555_AAAA);
      send_request(MODE_INSERT, 32'd2047, 64'hAAAA);
      send_request(MODE_INSERT, 32'd1021, 64'h77);
      send_request(MODE_INSERT, 32'd1024, 64'h88);
      send_request(MODE_LOOKUP, 32'd1023, '0);
      send_request(MODE_LOOKUP, 32'hFFFF_FFFF, '0);
      send_request(MODE_LOOKUP, 32'd2047, '0);
      send_request(MODE_REMOVE, 32'd1023, '0);
      send_request(MODE_LOOKUP, 32'd2047, '0);
      send_request(MODE_REMOVE, 32'd0, '0);
      send_request(MODE_REMOVE, 32'd0, '0);
      send_request(MODE_LOOKUP, 32'd1024, '0);
      used_keys = '{32'd1024, 32'd2047, 32'hFFFF_FFFF, 32'd1021};

      // Random part: chain-heavy operations over a shared key pool.
      for (int i = 0; i < 100; i++) begin
         k = chained_key();
         case ($urandom_range(0, 19))
            0: m = MODE_NONE;
            1, 2, 3, 4, 5, 6, 7, 8: m = MODE_INSERT;
            9, 10, 11, 12, 13: m = MODE_LOOKUP;
            default: m = MODE_REMOVE;
         endcase
         if (m == MODE_INSERT && used_keys.size() < 200) used_keys.push_back(k);
         send_request(m, k, {$urandom(), $urandom()});
      end

      // Fill the table until the model's free list is empty, then probe the full case.
      fill = 0;
      while (table_model.free_head != -1 && fill < 1100) begin
         send_request(MODE_INSERT, 32'd5000 + fill, {$urandom(), $urandom()});
         fill++;
      end
      send_request(MODE_INSERT, 32'd9000 * 1024 + 3, '1);
      send_request(MODE_INSERT, 32'h8000_0001, '1);
      send_request(MODE_LOOKUP, 32'd5000, '0);
      req_chan.valid <= 1'b0;

      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Sent %0d requests, checked %0d results, %0d lookup hits.",
               sent, table_model.checked, table_model.hits);
      $display("Directed corner cases, chained random traffic and a full table were covered.");
      if (table_model.errors == 0 && table_model.pending.size() == 0) begin
         $display("hash_table_internal_chaining_unit: match");
      end else begin
         $display("%0d mismatches", table_model.errors);
         $display("hash_table_internal_chaining_unit: mismatch");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/htc_pkg.sv
hdl/htc_if.sv
hdl/htc_mod.sv
hdl/htc_mem.sv
hdl/htc_ctrl.sv
hdl/hash_table_internal_chaining_unit.sv
verif/htc_tb_if.sv
verif/hash_table_internal_chaining_unit_test.sv
